// ----- hdl/smrm_pkg.sv -----
package smrm_pkg;

   localparam int CMD_W  = 2;
   localparam int SET_W  = 64;
   localparam int TAG_W  = 16;

   localparam int DEF_SET_BITS      = 64;
   localparam int DEF_SAT_ENTRIES   = 64;
   localparam int DEF_UNSAT_ENTRIES = 64;
   localparam int DEF_TAG_BITS      = 16;

   localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INS_SAT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INS_UNSAT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAT_SCAN,
      ST_UNS_SCAN,
      ST_PURGE,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/subset_match_result_memo.sv -----
// Lookup: scans the stored satisfiable entries, then the unsatisfiable ones, until a match;
//   one entry per cycle.
// Unsatisfiable insert: scans the stored unsatisfiable entries to drop their supersets.
// One word in flight: req_ready is high only while the sequencer is idle, so the next
//   word is taken no earlier than the cycle the previous result goes valid.
// Synchronous reset empties both tables (counts to zero) and drops any pending result.
module subset_match_result_memo #(
   parameter int SET_BITS      = smrm_pkg::DEF_SET_BITS,
   parameter int SAT_ENTRIES   = smrm_pkg::DEF_SAT_ENTRIES,
   parameter int UNSAT_ENTRIES = smrm_pkg::DEF_UNSAT_ENTRIES,
   parameter int TAG_BITS      = smrm_pkg::DEF_TAG_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [smrm_pkg::CMD_W-1:0]  req_command,
   input  logic [smrm_pkg::SET_W-1:0]  req_assumption_bits,
   input  logic [smrm_pkg::TAG_W-1:0]  req_core_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic                        rsp_is_satisfiable,
   output logic [smrm_pkg::TAG_W-1:0]  rsp_matched_core,
   output logic                        rsp_status
);

   import smrm_pkg::*;

   localparam int TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam int SCNT_W   = $clog2(SAT_ENTRIES + 1);
   localparam int UCNT_W   = $clog2(UNSAT_ENTRIES + 1);
   localparam int SIDX_W   = (SAT_ENTRIES > 1) ? $clog2(SAT_ENTRIES) : 1;
   localparam int UIDX_W   = (UNSAT_ENTRIES > 1) ? $clog2(UNSAT_ENTRIES) : 1;
   localparam int CW       = (SCNT_W > UCNT_W) ? SCNT_W : UCNT_W;

   state_type state_ff, state_in;

   logic [SET_BITS-1:0] q_ff, q_in;
   logic [TAG_KEEP-1:0] tag_ff, tag_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [UCNT_W-1:0]   keep_ff, keep_in;
   logic [SCNT_W-1:0]   sat_count_ff, sat_count_in;
   logic [UCNT_W-1:0]   unsat_count_ff, unsat_count_in;

   logic                res_found_ff, res_found_in;
   logic                res_sat_ff, res_sat_in;
   logic [TAG_KEEP-1:0] res_core_ff, res_core_in;
   logic                res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_sat_ff, rsp_sat_in;
   logic [TAG_KEEP-1:0] rsp_core_ff, rsp_core_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                sat_wr_en, sat_rd_en;
   logic [SIDX_W-1:0]   sat_wr_addr;
   logic [SET_BITS-1:0] sat_wr_data, sat_rd_data;

   logic                uns_wr_en, uns_rd_en;
   logic [UIDX_W-1:0]   uns_wr_addr;
   logic [SET_BITS-1:0] uns_wr_data, uns_rd_data;
   logic [TAG_KEEP-1:0] core_wr_data, core_rd_data;

   logic                accept;
   logic [CW-1:0]       scan_lim;
   logic                more;
   logic [SET_BITS-1:0] cmp_big, cmp_small;
   logic                hit, match, scan_end, out_free;

   smrm_store #(.DEPTH(SAT_ENTRIES), .WIDTH(SET_BITS)) u_sat_sets (
      .clock   (clock),
      .wr_en   (sat_wr_en),
      .wr_addr (sat_wr_addr),
      .wr_data (sat_wr_data),
      .rd_en   (sat_rd_en),
      .rd_addr (scan_ff[SIDX_W-1:0]),
      .rd_data (sat_rd_data)
   );

   smrm_store #(.DEPTH(UNSAT_ENTRIES), .WIDTH(SET_BITS)) u_unsat_sets (
      .clock   (clock),
      .wr_en   (uns_wr_en),
      .wr_addr (uns_wr_addr),
      .wr_data (uns_wr_data),
      .rd_en   (uns_rd_en),
      .rd_addr (scan_ff[UIDX_W-1:0]),
      .rd_data (uns_rd_data)
   );

   smrm_store #(.DEPTH(UNSAT_ENTRIES), .WIDTH(TAG_KEEP)) u_unsat_cores (
      .clock   (clock),
      .wr_en   (uns_wr_en),
      .wr_addr (uns_wr_addr),
      .wr_data (core_wr_data),
      .rd_en   (uns_rd_en),
      .rd_addr (scan_ff[UIDX_W-1:0]),
      .rd_data (core_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign scan_lim = (state_ff == ST_SAT_SCAN) ? CW'(sat_count_ff) : CW'(unsat_count_ff);
   assign more     = scan_ff < scan_lim;

   // shared subset compare: hit when big holds every bit of small
   always_comb begin
      case (state_ff)
         ST_SAT_SCAN: begin
            cmp_big   = sat_rd_data;
            cmp_small = q_ff;
         end
         ST_UNS_SCAN: begin
            cmp_big   = q_ff;
            cmp_small = uns_rd_data;
         end
         default: begin
            cmp_big   = uns_rd_data;
            cmp_small = q_ff;
         end
      endcase
   end

   assign hit      = (cmp_small & ~cmp_big) == '0;
   assign match    = pend_ff && hit;
   assign scan_end = !pend_ff && !more;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_LOOKUP:    state_in = ST_SAT_SCAN;
                  CMD_INS_UNSAT: state_in = ST_PURGE;
                  default:       state_in = ST_RESP;
               endcase
            end
         end
         ST_SAT_SCAN: begin
            if (match) begin
               state_in = ST_RESP;
            end else if (scan_end) begin
               state_in = ST_UNS_SCAN;
            end
         end
         ST_UNS_SCAN: begin
            if (match || scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_PURGE: begin
            if (scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_in           = q_ff;
      tag_in         = tag_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      keep_in        = keep_ff;
      sat_count_in   = sat_count_ff;
      unsat_count_in = unsat_count_ff;
      res_found_in   = res_found_ff;
      res_sat_in     = res_sat_ff;
      res_core_in    = res_core_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_sat_in     = rsp_sat_ff;
      rsp_core_in    = rsp_core_ff;
      rsp_status_in  = rsp_status_ff;
      sat_wr_en      = 1'b0;
      sat_wr_addr    = sat_count_ff[SIDX_W-1:0];
      sat_wr_data    = req_assumption_bits[SET_BITS-1:0];
      sat_rd_en      = 1'b0;
      uns_wr_en      = 1'b0;
      uns_wr_addr    = keep_ff[UIDX_W-1:0];
      uns_wr_data    = uns_rd_data;
      core_wr_data   = core_rd_data;
      uns_rd_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               q_in          = req_assumption_bits[SET_BITS-1:0];
               tag_in        = req_core_tag[TAG_KEEP-1:0];
               scan_in       = '0;
               pend_in       = 1'b0;
               keep_in       = '0;
               res_found_in  = 1'b0;
               res_sat_in    = 1'b0;
               res_core_in   = '0;
               res_status_in = 1'b0;
               if (req_command == CMD_INS_SAT) begin
                  if (sat_count_ff < SCNT_W'(SAT_ENTRIES)) begin
                     sat_wr_en    = 1'b1;
                     sat_count_in = SCNT_W'(sat_count_ff + 1'b1);
                  end else begin
                     res_status_in = 1'b1;
                  end
               end
            end
         end
         ST_SAT_SCAN: begin
            sat_rd_en = more;
            pend_in   = more;
            if (more) begin
               scan_in = CW'(scan_ff + 1'b1);
            end
            if (match) begin
               res_found_in = 1'b1;
               res_sat_in   = 1'b1;
            end else if (scan_end) begin
               // restart the index for the unsatisfiable pass
               scan_in = '0;
               pend_in = 1'b0;
            end
         end
         ST_UNS_SCAN: begin
            uns_rd_en = more;
            pend_in   = more;
            if (more) begin
               scan_in = CW'(scan_ff + 1'b1);
            end
            if (match) begin
               res_found_in = 1'b1;
               res_core_in  = core_rd_data;
            end
         end
         ST_PURGE: begin
            uns_rd_en = more;
            pend_in   = more;
            if (more) begin
               scan_in = CW'(scan_ff + 1'b1);
            end
            if (pend_ff && !hit) begin
               // compact: keep the entry at the next free slot
               uns_wr_en = 1'b1;
               keep_in   = UCNT_W'(keep_ff + 1'b1);
            end
            if (scan_end) begin
               uns_wr_data  = q_ff;
               core_wr_data = tag_ff;
               if (keep_ff < UCNT_W'(UNSAT_ENTRIES)) begin
                  uns_wr_en      = 1'b1;
                  unsat_count_in = UCNT_W'(keep_ff + 1'b1);
               end else begin
                  unsat_count_in = keep_ff;
                  res_status_in  = 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_sat_in    = res_sat_ff;
               rsp_core_in   = res_core_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_ff        <= 1'b0;
         sat_count_ff   <= '0;
         unsat_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         sat_count_ff   <= sat_count_in;
         unsat_count_ff <= unsat_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      tag_ff        <= tag_in;
      scan_ff       <= scan_in;
      keep_ff       <= keep_in;
      res_found_ff  <= res_found_in;
      res_sat_ff    <= res_sat_in;
      res_core_ff   <= res_core_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_sat_ff    <= rsp_sat_in;
      rsp_core_ff   <= rsp_core_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_is_satisfiable = rsp_sat_ff;
   assign rsp_matched_core   = TAG_W'(rsp_core_ff);
   assign rsp_status         = rsp_status_ff;

endmodule

// ----- hdl/smrm_store.sv -----
module smrm_store #(
   parameter int DEPTH = smrm_pkg::DEF_SAT_ENTRIES,
   parameter int WIDTH = smrm_pkg::DEF_SET_BITS,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/smrm_checker.sv -----
module smrm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_found,
   input logic                       rsp_is_satisfiable,
   input logic [smrm_pkg::TAG_W-1:0] rsp_matched_core,
   input logic                       rsp_status
);

   // one word at a time: no new request right after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high the cycle after an accept");

   a_sat_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_satisfiable |-> rsp_found && rsp_matched_core == '0)
      else $error("satisfiable response without found or with nonzero core");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> !rsp_is_satisfiable && rsp_matched_core == '0)
      else $error("miss or insert response carries match fields");

   a_drop_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_found)
      else $error("dropped-insert flag on a lookup match");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_matched_core) && $stable(rsp_status))
      else $error("response word changed while stalled");

endmodule

bind subset_match_result_memo smrm_checker u_smrm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_found          (rsp_found),
   .rsp_is_satisfiable (rsp_is_satisfiable),
   .rsp_matched_core   (rsp_matched_core),
   .rsp_status         (rsp_status)
);

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smrm_pkg::*;

   localparam int SAT_N        = DEF_SAT_ENTRIES;
   localparam int UNSAT_N      = DEF_UNSAT_ENTRIES;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 160;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_WORDS  = 300;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic             found;
      logic             is_sat;
      logic [TAG_W-1:0] core;
      logic             status;
   } memo_answer_type;

   class memo_board;
      logic [SET_W-1:0] sat_tab[SAT_N];
      int               sat_n;
      logic [SET_W-1:0] unsat_tab[UNSAT_N];
      logic [TAG_W-1:0] core_tab[UNSAT_N];
      int               unsat_n;
      memo_answer_type  awaited[$];
      int               errors;

      function void note_request(logic [CMD_W-1:0] cmd, logic [SET_W-1:0] bits,
                                 logic [TAG_W-1:0] tag);
         memo_answer_type ans;
         int keep;
         ans = '0;
         case (cmd)
            CMD_LOOKUP: begin
               // satisfiable supersets win over unsatisfiable subsets
               for (int i = 0; i < sat_n; i++) begin
                  if ((bits & ~sat_tab[i]) == '0) begin
                     ans.found  = 1'b1;
                     ans.is_sat = 1'b1;
                     break;
                  end
               end
               if (!ans.found) begin
                  for (int i = 0; i < unsat_n; i++) begin
                     if ((unsat_tab[i] & ~bits) == '0) begin
                        ans.found = 1'b1;
                        ans.core  = core_tab[i];
                        break;
                     end
                  end
               end
            end
            CMD_INS_SAT: begin
               if (sat_n < SAT_N) begin
                  sat_tab[sat_n] = bits;
                  sat_n++;
               end else begin
                  ans.status = 1'b1;
               end
            end
            CMD_INS_UNSAT: begin
               // drop stored supersets, keep order of the rest
               keep = 0;
               for (int i = 0; i < unsat_n; i++) begin
                  if ((bits & ~unsat_tab[i]) != '0) begin
                     unsat_tab[keep] = unsat_tab[i];
                     core_tab[keep]  = core_tab[i];
                     keep++;
                  end
               end
               unsat_n = keep;
               if (unsat_n < UNSAT_N) begin
                  unsat_tab[unsat_n] = bits;
                  core_tab[unsat_n]  = tag;
                  unsat_n++;
               end else begin
                  ans.status = 1'b1;
               end
            end
            default: ;
         endcase
         awaited.insert(awaited.size(), ans);
      endfunction

      function void compare(string what, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_result(memo_answer_type got);
         memo_answer_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected word found=%b sat=%b core=%h status=%b",
                     $time, got.found, got.is_sat, got.core, got.status);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare("found", TAG_W'(want.found), TAG_W'(got.found));
         compare("is_satisfiable", TAG_W'(want.is_sat), TAG_W'(got.is_sat));
         compare("matched_core", want.core, got.core);
         compare("status", TAG_W'(want.status), TAG_W'(got.status));
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CMD_W-1:0] req_command = CMD_LOOKUP;
   logic [SET_W-1:0] req_assumption_bits = '0;
   logic [TAG_W-1:0] req_core_tag = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic             rsp_is_satisfiable;
   logic [TAG_W-1:0] rsp_matched_core;
   logic             rsp_status;

   memo_board board;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asks      = 0;
   int hold_taken     = 0;
   int hold_left      = 0;

   subset_match_result_memo uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_assumption_bits(req_assumption_bits),
      .req_core_tag       (req_core_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_is_satisfiable (rsp_is_satisfiable),
      .rsp_matched_core   (rsp_matched_core),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("subset_match_result_memo: mismatch");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      memo_answer_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.found  = rsp_found;
         seen.is_sat = rsp_is_satisfiable;
         seen.core   = rsp_matched_core;
         seen.status = rsp_status;
         board.check_result(seen);
      end
   end

   function automatic logic [SET_W-1:0] rand_bits();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SET_W-1:0] sparse_set(int k);
      logic [SET_W-1:0] v;
      v = '0;
      repeat (k) v[$urandom_range(0, SET_W - 1)] = 1'b1;
      return v;
   endfunction

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [SET_W-1:0] bits,
                            logic [TAG_W-1:0] tag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_assumption_bits <= bits;
      req_core_tag        <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(cmd, bits, tag);
   endtask

   task automatic send_random();
      logic [CMD_W-1:0] cmd;
      logic [SET_W-1:0] bits;
      int r;
      int kind;
      r    = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      if (r < 45) begin
         cmd = CMD_LOOKUP;
         if (kind < 3) begin
            bits = sparse_set($urandom_range(1, 12));
         end else if (kind < 5 && board.sat_n > 0) begin
            bits = board.sat_tab[$urandom_range(0, board.sat_n - 1)] & rand_bits();
         end else if (kind < 7 && board.unsat_n > 0) begin
            bits = board.unsat_tab[$urandom_range(0, board.unsat_n - 1)] |
                   sparse_set($urandom_range(0, 6));
         end else if (kind == 8 && board.sat_n > 0) begin
            bits = board.sat_tab[$urandom_range(0, board.sat_n - 1)] | sparse_set(1);
         end else if (kind == 9) begin
            bits = rand_bits() | rand_bits();
         end else begin
            bits = rand_bits();
         end
      end else if (r < 60) begin
         cmd = CMD_INS_SAT;
         if (kind < 7) bits = rand_bits() & rand_bits() & rand_bits();
         else if (kind < 9) bits = sparse_set($urandom_range(1, 6));
         else bits = rand_bits();
      end else if (r < 92) begin
         cmd = CMD_INS_UNSAT;
         if (kind < 5) begin
            bits = sparse_set($urandom_range(1, 4));
         end else if (kind < 8 && board.unsat_n > 0) begin
            // strip a bit from a stored set to purge it
            bits = board.unsat_tab[$urandom_range(0, board.unsat_n - 1)] & ~sparse_set(1);
         end else if (kind == 9) begin
            bits = rand_bits();
         end else begin
            bits = sparse_set($urandom_range(5, 10));
         end
      end else begin
         cmd  = CMD_SPARE;
         bits = rand_bits();
      end
      send_word(cmd, bits, TAG_W'($urandom_range(0, 65535)));
   endtask

   // one-hot sets never contain each other, so the table ends up full
   task automatic fill_unsat();
      int order[SET_W];
      int j;
      int t;
      int a;
      int b;
      for (int i = 0; i < SET_W; i++) order[i] = i;
      for (int i = SET_W - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < SET_W; i++) begin
         send_word(CMD_INS_UNSAT, SET_W'(1) << order[i], TAG_W'($urandom_range(0, 65535)));
      end
      a = $urandom_range(0, SET_W - 1);
      b = (a + $urandom_range(1, SET_W - 1)) % SET_W;
      send_word(CMD_INS_UNSAT, (SET_W'(1) << a) | (SET_W'(1) << b),
                TAG_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_LOOKUP, '0, '0);
      send_word(CMD_LOOKUP, '1, '0);
      send_word(CMD_SPARE, '1, '1);
      send_word(CMD_INS_SAT, '0, '1);
      send_word(CMD_LOOKUP, '0, '0);
      send_word(CMD_INS_SAT, 64'h00FF_00FF_0F0F_3333, 16'h0000);
      send_word(CMD_LOOKUP, 64'h0000_000F_0003_0003, 16'h0000);
      send_word(CMD_LOOKUP, 64'h8000_0000_0000_0000, 16'h0000);
      send_word(CMD_INS_UNSAT, '1, 16'hFFFF);
      send_word(CMD_LOOKUP, '1, '0);
      send_word(CMD_INS_UNSAT, 64'h8000_0000_0000_0001, 16'h0000);
      send_word(CMD_INS_UNSAT, 64'h0000_0000_0000_0100, 16'h1234);
      send_word(CMD_LOOKUP, 64'h8000_0000_0000_0101, 16'h0000);
      send_word(CMD_LOOKUP, 64'h0000_0000_0000_0300, 16'h0000);
      send_word(CMD_LOOKUP, '1, '1);
      send_word(CMD_INS_UNSAT, '0, 16'hA5A5);
      send_word(CMD_LOOKUP, 64'h4000_0000_0000_0000, 16'h0000);
      send_word(CMD_LOOKUP, '0, '0);
      send_word(CMD_SPARE, '0, '0);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         if (p == 1) fill_unsat();
         if (p == 2) hold_asks++;
         repeat (PHASE_WORDS) send_random();
      end
      req_valid <= 1'b0;

      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("subset_match_result_memo: match");
      end else begin
         $display("subset_match_result_memo: mismatch");
      end
      $finish;
   end
endmodule

// ----- subset_match_result_memo.f -----
hdl/smrm_pkg.sv
hdl/smrm_store.sv
hdl/subset_match_result_memo.sv
hdl/smrm_checker.sv
dv/tb.sv
